/* src/demand_paging_translator_core_assert.svh */
// Assertion macros used by the translator core to check its own logic.
`ifndef DEMAND_PAGING_TRANSLATOR_CORE_ASSERT_SVH
`define DEMAND_PAGING_TRANSLATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* src/dpt_pkg.sv */
package dpt_pkg;

	localparam int PAGE_SIZE = 256;
	localparam int NUM_PAGES = 256;

	localparam int ADDR_W   = 16;
	localparam int OFFSET_W = $clog2(PAGE_SIZE);
	localparam int PAGE_W   = $clog2(NUM_PAGES);
	localparam int FRAME_W  = 8;
	localparam int NEXT_W   = 9;
	localparam int COUNT_W  = 16;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_LOOKUP
	} dpt_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dpt_cmd_t;

endpackage

/* src/dpt_va_if.sv */
interface dpt_va_if import dpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink   (input valid, input virtual_address, output ready);
endinterface

/* src/dpt_pa_if.sv */
interface dpt_pa_if import dpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  physical_address;
	logic               page_fault;
	logic [COUNT_W-1:0] fault_total;

	modport source (output valid, output physical_address, output page_fault,
		output fault_total, input ready);
	modport sink   (input valid, input physical_address, input page_fault,
		input fault_total, output ready);
endinterface

/* src/dpt_ram.sv */
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/dpt_ctrl.sv */
module dpt_ctrl import dpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output dpt_cmd_t cmd
);

	dpt_state_t state_q, state_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// The result may only be loaded once the output register is free.
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* src/dpt_datapath.sv */
module dpt_datapath import dpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dpt_cmd_t           cmd,
	input  logic [ADDR_W-1:0]  virtual_address,
	output logic [ADDR_W-1:0]  physical_address,
	output logic               page_fault,
	output logic [COUNT_W-1:0] fault_total
);

	logic [ADDR_W-1:0]    va_q;
	logic [NUM_PAGES-1:0] valid_q;
	logic [NEXT_W-1:0]    next_frame_q;
	logic [COUNT_W-1:0]   fault_cnt_q;
	logic [ADDR_W-1:0]    phys_q;
	logic                 fault_q;
	logic [COUNT_W-1:0]   total_q;

	logic [2*ADDR_W-1:0]  shifted_in, shifted_held;
	logic [PAGE_W-1:0]    page_in, page_q, ram_raddr;
	logic [OFFSET_W-1:0]  offset_q;
	logic [FRAME_W-1:0]   ram_rdata, frame;
	logic                 hit, ram_we;
	logic [COUNT_W-1:0]   fault_cnt_d;
	logic [2*ADDR_W-1:0]  phys_wide;

	// The page number wraps within the table.
	assign shifted_in   = {{ADDR_W{1'b0}}, virtual_address} >> OFFSET_W;
	assign page_in      = shifted_in[PAGE_W-1:0];
	assign shifted_held = {{ADDR_W{1'b0}}, va_q} >> OFFSET_W;
	assign page_q       = shifted_held[PAGE_W-1:0];
	assign offset_q     = va_q[OFFSET_W-1:0];

	// Once a beat has been captured the read keeps pointing at its page, so the
	// frame stays put while the result waits for the output register.
	assign ram_raddr = cmd.capture ? page_in : page_q;

	assign hit    = valid_q[page_q];
	assign ram_we = cmd.commit && !hit;
	assign frame  = hit ? ram_rdata : next_frame_q[FRAME_W-1:0];

	always_comb begin
		fault_cnt_d = fault_cnt_q;
		if (!hit && (fault_cnt_q != {COUNT_W{1'b1}})) begin
			fault_cnt_d = fault_cnt_q + COUNT_W'(1);
		end
	end

	assign phys_wide = ({{(2*ADDR_W-FRAME_W){1'b0}}, frame} << OFFSET_W)
		| {{(2*ADDR_W-OFFSET_W){1'b0}}, offset_q};

	dpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (NUM_PAGES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (page_q),
		.wdata (next_frame_q[FRAME_W-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			next_frame_q <= '0;
			fault_cnt_q  <= '0;
		end else if (ram_we) begin
			valid_q[page_q] <= 1'b1;
			next_frame_q    <= next_frame_q + NEXT_W'(1);
			fault_cnt_q     <= fault_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q <= virtual_address;
		end
		if (cmd.commit) begin
			phys_q  <= phys_wide[ADDR_W-1:0];
			fault_q <= !hit;
			total_q <= fault_cnt_d;
		end
	end

	assign physical_address = phys_q;
	assign page_fault       = fault_q;
	assign fault_total      = total_q;

endmodule

/* src/demand_paging_translator_core.sv */
// Demand-paging address translator. Each request beat carries a 16-bit virtual
// address, split into a page number (upper bits) and an offset (lower bits), and
// each produces exactly one response beat with the physical address, a page-fault
// flag and the saturating count of faults since reset. A page seen for the first
// time is given the next free frame in sequence and is mapped from then on. On
// acceptance the frame memory is read into its output register; the lookup state
// then resolves the hit or fault, updates the table and loads the output register,
// and no new request is accepted until it has done so. The result stage waits only
// while the previous response has not been taken, and a new request is accepted
// while a finished response is still waiting. The page valid bits sit in
// flip-flops that reset clears at once, so the block is ready straight after
// reset with no clearing pass.

`include "demand_paging_translator_core_assert.svh"

module demand_paging_translator_core import dpt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	dpt_va_if.sink   request,
	dpt_pa_if.source response
);

	dpt_cmd_t cmd;

	// The controller sequences each beat; the datapath holds the table and counters.
	dpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (response.valid),
		.rsp_ready (response.ready),
		.cmd       (cmd)
	);

	dpt_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.virtual_address  (request.virtual_address),
		.physical_address (response.physical_address),
		.page_fault       (response.page_fault),
		.fault_total      (response.fault_total)
	);

	// A lookup is in flight for the cycle after a request beat is taken.
	`DPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, request.valid && request.ready, !request.ready)
	// A committed lookup always leaves a response on offer.
	`DPT_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, response.valid)
	// A faulting response can never report a zero fault count.
	`DPT_ASSERT_SAME(a_fault_counted, clk, arst_n, response.valid && response.page_fault, response.fault_total != '0)

endmodule
